/* hdl/mrrl_pkg.sv */
`timescale 1ns / 1ps
package mrrl_pkg;

    // Field widths
    localparam int ID_W    = 16;
    localparam int SRC_W   = 8;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = ID_W + SRC_W + TIME_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED    = 2'd1;

    localparam logic [TIME_W-1:0] WINDOW_RESET  = 32'd1000;
    localparam logic [SRC_W-1:0]  WATCHED_RESET = 8'd0;

    // Operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic push_wr;
        logic walk_load;
        logic walk_step;
        logic res_load;
        logic res_val;
        logic out_load;
    } mrrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic zero_interval;
        logic stop;
        logic hit;
        logic last;
    } mrrl_status_t;

endpackage

/* hdl/mrrl_ram.sv */
`timescale 1ns / 1ps
module mrrl_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/mrrl_ctrl.sv */
`timescale 1ns / 1ps
module mrrl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  mrrl_pkg::mrrl_status_t status,
    output mrrl_pkg::mrrl_cmd_t    cmd
);

    import mrrl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_accept;
    logic        out_take;
    logic        out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || out_take;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (op == OP_QUERY))
                begin
                    state_next = status.zero_interval ? ST_FIN : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.stop || status.hit || status.last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == OP_PUSH)
                    begin
                        cmd.push_wr = 1'b1;
                    end
                    else if (status.zero_interval)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_val  = 1'b0;
                    end
                    else
                    begin
                        cmd.walk_load = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                if (status.stop)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_val  = 1'b0;
                end
                else if (status.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_val  = 1'b1;
                end
                else if (status.last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_val  = 1'b0;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output beat valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/mrrl_dp.sv */
`timescale 1ns / 1ps
module mrrl_dp #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [mrrl_pkg::ID_W-1:0]            msg_id,
    input  logic [mrrl_pkg::SRC_W-1:0]           source,
    input  logic [mrrl_pkg::TIME_W-1:0]          now_ms,
    input  logic [mrrl_pkg::TIME_W-1:0]          interval_ms,
    input  logic                                 cfg_we,
    input  logic [mrrl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mrrl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  mrrl_pkg::mrrl_cmd_t                   cmd,
    output mrrl_pkg::mrrl_status_t                status,
    output logic                                 limited
);

    import mrrl_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    logic [TIME_W-1:0]        window_reg;
    logic [SRC_W-1:0]         watched_reg;
    logic [AW-1:0]            wp_reg;
    logic [AW-1:0]            idx_reg;
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [ID_W-1:0]          qid_reg;
    logic [TIME_W-1:0]        qnow_reg;
    logic [TIME_W-1:0]        qint_reg;
    logic                     res_reg;
    logic                     limited_reg;

    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic [ID_W-1:0]    e_id;
    logic [SRC_W-1:0]   e_src;
    logic [TIME_W-1:0]  e_stamp;
    logic [TIME_W-1:0]  age;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RESET;
            watched_reg <= WATCHED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_WINDOW: window_reg  <= cfg_data;
                CFG_WATCHED:    watched_reg <= cfg_data[SRC_W-1:0];
                default:        ;
            endcase
        end
    end

    // Write pointer, walk index and slot valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            idx_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.push_wr)
            begin
                wp_reg            <= idx_inc(wp_reg);
                valid_reg[wp_reg] <= 1'b1;
            end
            if (cmd.walk_load || cmd.walk_step)
            begin
                idx_reg <= rd_addr;
            end
        end
    end

    // Hold query fields for the walk, the walk result and the output result
    always_ff @(posedge clk)
    begin
        if (cmd.walk_load)
        begin
            qid_reg  <= msg_id;
            qnow_reg <= now_ms;
            qint_reg <= interval_ms;
        end
        if (cmd.res_load)
        begin
            res_reg <= cmd.res_val;
        end
        if (cmd.out_load)
        begin
            limited_reg <= res_reg;
        end
    end

    // Fetch the newest slot on load, the next older one on each step
    always_comb
    begin
        if (cmd.walk_load)
        begin
            rd_addr = idx_dec(wp_reg);
        end
        else if (cmd.walk_step)
        begin
            rd_addr = idx_dec(idx_reg);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    assign wr_entry = {msg_id, source, now_ms};

    mrrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.push_wr),
        .waddr (wp_reg),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    // Evaluate the slot under the walk index
    assign e_id    = rd_entry[ENTRY_W-1 -: ID_W];
    assign e_src   = rd_entry[TIME_W +: SRC_W];
    assign e_stamp = rd_entry[TIME_W-1:0];
    assign age     = qnow_reg - e_stamp;

    assign status.zero_interval = (interval_ms == '0);
    assign status.stop = !valid_reg[idx_reg] || (e_id == '0) || (age >= window_reg);
    assign status.hit  = (e_id == qid_reg) && (e_src == watched_reg) && (age < qint_reg);
    assign status.last = (idx_dec(idx_reg) == wp_reg);

    assign limited = limited_reg;

endmodule

/* hdl/message_repeat_rate_limiter_core.sv */
`timescale 1ns / 1ps
// Message repeat rate limiter.
// Input channel (in_valid / in_stall) carries op, msg_id, source, now_ms and
// interval_ms. A push (op 0) stores the message in a ring of HISTORY_DEPTH
// slots and gives no result; a query (op 1) gives one beat on the output
// channel (out_valid / out_stall) with limited set when the same ID from the
// watched source was pushed less than interval_ms ago.
// A push is written in the idle state. A query walks the history RAM one slot
// per cycle, newest first, up to HISTORY_DEPTH-1 slots, and holds the input
// while it walks and finishes (a zero interval goes straight to the finish
// state); the finish state loads the result beat into the output register.
// The single read port of the history RAM sets the walk rate.
// The output register decouples the sides: a new item is taken while an
// earlier result waits; a finished query waits for the register to free up
// while out_stall is high.
// Config writes (cfg_valid / cfg_ready, always ready): index 0 max_window_ms,
// index 1 watched_source; other indexes are dropped. Write only when idle.
// Reset (rst_n low) marks every slot empty, clears the write pointer and
// returns the registers to window 1000 ms and source 0.
module message_repeat_rate_limiter_core #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic [mrrl_pkg::ID_W-1:0]            msg_id,
    input  logic [mrrl_pkg::SRC_W-1:0]           source,
    input  logic [mrrl_pkg::TIME_W-1:0]          now_ms,
    input  logic [mrrl_pkg::TIME_W-1:0]          interval_ms,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 limited,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mrrl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mrrl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import mrrl_pkg::*;

    mrrl_cmd_t    cmd;
    mrrl_status_t status;
    logic         cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    mrrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mrrl_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_id      (msg_id),
        .source      (source),
        .now_ms      (now_ms),
        .interval_ms (interval_ms),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .limited     (limited)
    );

endmodule

/* tb/message_repeat_rate_limiter_core_test.sv */
`timescale 1ns / 1ps
module message_repeat_rate_limiter_core_test;

    import mrrl_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DRAIN_WAIT  = DEPTH + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    // Register indexes that the block must drop
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic              op;
        logic [ID_W-1:0]   msg_id;
        logic [SRC_W-1:0]  source;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] interval_ms;
    } msg_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SRC_W-1:0]  src;
        logic [TIME_W-1:0] stamp;
        logic              valid;
    } slot_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  op = OP_PUSH;
    logic [ID_W-1:0]       msg_id = '0;
    logic [SRC_W-1:0]      source = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic [TIME_W-1:0]     interval_ms = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  limited;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the block's history and registers
    slot_t             ring [DEPTH];
    int unsigned       wr_ptr;
    logic [TIME_W-1:0] window_ms;
    logic [SRC_W-1:0]  watch_src;

    msg_beat_t         pending [$];
    bit                limited_due [$];
    msg_beat_t         cur_beat;
    logic [TIME_W-1:0] clock_ms;

    int  err_count = 0;
    int  n_results = 0;
    int  n_accepted = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    int  next_hold_at = 300;
    bit  hold_on = 1'b0;
    bit  exp_limited;
    bit  stall_now;
    int  cycle_count = 0;

    message_repeat_rate_limiter_core #(
        .HISTORY_DEPTH (DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .msg_id      (msg_id),
        .source      (source),
        .now_ms      (now_ms),
        .interval_ms (interval_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .limited     (limited),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = ~clk;
    end

    // Walk back from the newest slot, skipping the oldest one
    function automatic bit repeat_too_soon(input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] now,
                                           input logic [TIME_W-1:0] interval);
        int unsigned       idx;
        logic [TIME_W-1:0] age;
        if (interval == '0)
            return 1'b0;
        idx = (wr_ptr + DEPTH - 1) % DEPTH;
        while (idx != wr_ptr)
        begin
            if (!ring[idx].valid || ring[idx].id == '0)
                return 1'b0;
            age = now - ring[idx].stamp;
            if (age >= window_ms)
                return 1'b0;
            if (ring[idx].id == id && ring[idx].src == watch_src && age < interval)
                return 1'b1;
            idx = (idx + DEPTH - 1) % DEPTH;
        end
        return 1'b0;
    endfunction

    // Apply one accepted beat to the shadow history
    task automatic track_beat(input msg_beat_t b);
        if (b.op == OP_PUSH)
        begin
            ring[wr_ptr] = '{id: b.msg_id, src: b.source, stamp: b.now_ms, valid: 1'b1};
            wr_ptr = (wr_ptr + 1) % DEPTH;
        end
        else
            limited_due.push_back(repeat_too_soon(b.msg_id, b.now_ms, b.interval_ms));
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic queue_beat(input logic o, input logic [ID_W-1:0] id,
                              input logic [SRC_W-1:0] src, input logic [TIME_W-1:0] now,
                              input logic [TIME_W-1:0] interval);
        msg_beat_t b;
        b = '{op: o, msg_id: id, source: src, now_ms: now, interval_ms: interval};
        pending.push_back(b);
    endtask

    // Mostly coherent traffic on a small ID pool, with some raw noise
    task automatic queue_random(input int count);
        msg_beat_t b;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                b.op          = 1'($urandom);
                b.msg_id      = ID_W'($urandom);
                b.source      = SRC_W'($urandom);
                b.now_ms      = $urandom;
                b.interval_ms = $urandom;
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    clock_ms = clock_ms - $urandom_range(0, 2000);
                else
                    clock_ms = clock_ms + $urandom_range(0, 300);
                b.op = ($urandom_range(0, 9) < 6) ? OP_PUSH : OP_QUERY;
                case ($urandom_range(0, 9))
                    0: b.msg_id = '0;
                    1: b.msg_id = ID_W'($urandom);
                    default: b.msg_id = ID_W'($urandom_range(1, 4));
                endcase
                b.source = ($urandom_range(0, 9) < 7) ? watch_src : SRC_W'($urandom);
                b.now_ms = clock_ms;
                case ($urandom_range(0, 7))
                    0: b.interval_ms = '0;
                    1: b.interval_ms = '1;
                    2: b.interval_ms = $urandom;
                    default: b.interval_ms = $urandom_range(1, 1200);
                endcase
            end
            pending.push_back(b);
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending.size() != 0 || in_valid || limited_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_WINDOW)
            window_ms = data;
        else if (idx == CFG_WATCHED)
            watch_src = data[SRC_W-1:0];
    endtask

    // Drain, reprogram while idle, then run a random phase
    task automatic run_phase(input logic [TIME_W-1:0] window, input logic [SRC_W-1:0] src,
                             input int count);
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        write_reg(CFG_MAX_WINDOW, window);
        write_reg(CFG_WATCHED, CFG_DATA_W'(src));
        clock_ms = $urandom;
        queue_random(count);
        wait_idle();
    endtask

    // Driver: bursts with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            op          <= OP_PUSH;
            msg_id      <= '0;
            source      <= '0;
            now_ms      <= '0;
            interval_ms <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_beat(cur_beat);
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 && !hold_on)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    cur_beat = pending.pop_front();
                    op          <= cur_beat.op;
                    msg_id      <= cur_beat.msg_id;
                    source      <= cur_beat.source;
                    now_ms      <= cur_beat.now_ms;
                    interval_ms <= cur_beat.interval_ms;
                    in_valid    <= 1'b1;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            hold_on      <= 1'b0;
            next_hold_at <= 300;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            hold_on   <= (hold_left > 1);
        end
        else if (n_accepted >= next_hold_at && next_hold_at <= 700)
        begin
            hold_left    <= HOLD_CYCLES;
            hold_on      <= 1'b1;
            next_hold_at <= next_hold_at + 400;
        end
    end

    // Monitor: check each result beat, then pick the next stall value
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (limited_due.size() == 0)
                    report_mismatch($sformatf("result %0d with no query pending", n_results));
                else
                begin
                    exp_limited = limited_due.pop_front();
                    if (limited !== exp_limited)
                        report_mismatch($sformatf("result %0d limited=%b expected %b",
                                                  n_results, limited, exp_limited));
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            else
                mode_left = mode_left - 1;
            case (stall_mode)
                0: stall_now = 1'b0;
                1: stall_now = ($urandom_range(0, 3) == 0);
                2: stall_now = ($urandom_range(0, 3) != 0);
                default: stall_now = mode_left[1];
            endcase
            out_stall <= hold_on || stall_now;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            ring[i] = '0;
        wr_ptr    = 0;
        window_ms = WINDOW_RESET;
        watch_src = WATCHED_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks on the reset settings
        queue_beat(OP_QUERY, 16'd7, 8'd0, 32'd50, 32'd5);            // empty history
        queue_beat(OP_QUERY, 16'd7, 8'd0, 32'd50, 32'd0);            // zero interval
        queue_beat(OP_PUSH, 16'd7, 8'd0, 32'd100, 32'd0);
        queue_beat(OP_QUERY, 16'd7, 8'd0, 32'd150, 32'd100);         // repeat too soon
        queue_beat(OP_QUERY, 16'd7, 8'd0, 32'd150, 32'd50);          // age equals interval
        queue_beat(OP_PUSH, 16'd7, 8'd3, 32'd200, 32'd0);            // other source
        queue_beat(OP_QUERY, 16'd7, 8'd0, 32'd210, 32'd500);         // walk past other source
        queue_beat(OP_QUERY, 16'd7, 8'd0, 32'd1100, 32'hFFFF_FFFF);  // age at the window
        queue_beat(OP_PUSH, 16'd0, 8'd0, 32'd220, 32'd0);            // zero ID stored
        queue_beat(OP_QUERY, 16'd7, 8'd0, 32'd230, 32'd500);         // stop at zero ID
        queue_beat(OP_PUSH, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(OP_QUERY, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(OP_PUSH, 16'd5, 8'd0, 32'd0, 32'd0);              // zero timestamp
        queue_beat(OP_QUERY, 16'd5, 8'd0, 32'd10, 32'd20);           // hit on the zero timestamp
        queue_beat(OP_PUSH, 16'd9, 8'd0, 32'd5000, 32'd0);
        queue_beat(OP_QUERY, 16'd9, 8'd0, 32'd4000, 32'hFFFF_FFFF);  // stamp from the future
        queue_beat(OP_QUERY, 16'd9, 8'hFF, 32'd5001, 32'd10);        // source ignored on query
        wait_idle();

        clock_ms = $urandom;
        queue_random(160);
        wait_idle();

        // Spare indexes must not touch the registers
        repeat (DRAIN_WAIT) @(posedge clk);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);

        run_phase(32'd0, 8'h5A, 150);
        run_phase(32'hFFFF_FFFF, 8'hFF, 180);
        run_phase(TIME_W'($urandom_range(200, 5000)), SRC_W'($urandom), 180);
        run_phase(TIME_W'($urandom), SRC_W'($urandom), 160);
        run_phase(32'd1, 8'h00, 120);
        run_phase(WINDOW_RESET, WATCHED_RESET, 170);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
